### hdl/olso_pkg.sv
// ----------------------------------------------------------------------------
// olso_pkg
// Shared types and constants for the ordered list store.
// ----------------------------------------------------------------------------
`default_nettype none

package olso_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 6;

    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_EQUAL = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_SUCC  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;
    localparam logic [OP_W-1:0] OP_DUMP      = 3'd5;

    typedef struct packed {
        logic signed [VALUE_W-1:0] entry_value;
        logic                      found;
        logic                      dropped;
        logic [COUNT_W-1:0]        entry_count;
        logic                      last;
    } olso_res_t;

endpackage

`default_nettype wire

### hdl/olso_ram.sv
// ----------------------------------------------------------------------------
// olso_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module olso_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/olso_walk.sv
// ----------------------------------------------------------------------------
// olso_walk
// Request sequencer: appends at the tail, and walks the store once per
// search, removal or dump, compacting surviving entries in place.
// ----------------------------------------------------------------------------
`default_nettype none

module olso_walk #(
    parameter int DEPTH = olso_pkg::DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [olso_pkg::OP_W-1:0]        op,
    input  wire logic signed [olso_pkg::VALUE_W-1:0] operand_value,
    output logic                                  res_valid,
    input  wire logic                             res_ready,
    output olso_pkg::olso_res_t                   res,
    output logic                                  ram_wr_en,
    output logic [$clog2(DEPTH)-1:0]              ram_wr_addr,
    output logic [olso_pkg::VALUE_W-1:0]          ram_wr_data,
    output logic                                  ram_rd_en,
    output logic [$clog2(DEPTH)-1:0]              ram_rd_addr,
    input  wire logic [olso_pkg::VALUE_W-1:0]     ram_rd_data
);

    import olso_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [VALUE_W-1:0]  key_reg, key_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [CW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic                skip_reg, skip_next;
    logic                found_reg, found_next;
    logic                dropped_reg, dropped_next;
    logic                hit;
    logic                consume;

    assign hit      = (ram_rd_data == key_reg);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        len_next     = len_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        skip_next    = skip_reg;
        found_next   = found_reg;
        dropped_next = dropped_reg;
        consume      = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = '0;
        ram_wr_data  = '0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = '0;
        res_valid    = 1'b0;
        res          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = op;
                    key_next     = operand_value;
                    found_next   = 1'b0;
                    dropped_next = 1'b0;
                    skip_next    = 1'b0;
                    wr_ptr_next  = '0;
                    state_next   = ST_RESP;
                    case (op)
                        OP_APPEND:
                        begin
                            if (len_reg < CW'(DEPTH))
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = len_reg[AW-1:0];
                                ram_wr_data = operand_value;
                                len_next    = len_reg + 1'b1;
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        OP_SEARCH, OP_REM_EQUAL, OP_REM_SUCC, OP_DUMP:
                        begin
                            if (len_reg != '0)
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                rd_ptr_next = CW'(1);
                                state_next  = ST_WALK;
                            end
                        end
                        OP_CLEAR:
                        begin
                            len_next = '0;
                        end
                        default:
                        begin
                            len_next = len_reg;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                if (op_reg == OP_DUMP)
                begin
                    res_valid               = 1'b1;
                    res.entry_value         = ram_rd_data;
                    res.entry_count         = COUNT_W'(len_reg);
                    res.last                = (rd_ptr_reg == len_reg);
                    consume                 = res_ready;
                end
                else
                begin
                    consume = 1'b1;
                end

                if (consume)
                begin
                    case (op_reg)
                        OP_SEARCH:
                        begin
                            if (hit)
                            begin
                                found_next = 1'b1;
                            end
                        end
                        OP_REM_EQUAL:
                        begin
                            if (!hit)
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = wr_ptr_reg[AW-1:0];
                                ram_wr_data = ram_rd_data;
                                wr_ptr_next = wr_ptr_reg + 1'b1;
                            end
                        end
                        OP_REM_SUCC:
                        begin
                            if (skip_reg)
                            begin
                                skip_next = 1'b0;
                            end
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = wr_ptr_reg[AW-1:0];
                                ram_wr_data = ram_rd_data;
                                wr_ptr_next = wr_ptr_reg + 1'b1;
                                skip_next   = hit;
                            end
                        end
                        default:
                        begin
                            skip_next = skip_reg;
                        end
                    endcase

                    if (rd_ptr_reg == len_reg)
                    begin
                        if ((op_reg == OP_REM_EQUAL) || (op_reg == OP_REM_SUCC))
                        begin
                            len_next = wr_ptr_next;
                        end
                        state_next = (op_reg == OP_DUMP) ? ST_IDLE : ST_RESP;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = rd_ptr_reg[AW-1:0];
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                end
            end

            ST_RESP:
            begin
                res_valid       = 1'b1;
                res.found       = found_reg;
                res.dropped     = dropped_reg;
                res.entry_count = COUNT_W'(len_reg);
                res.last        = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            skip_reg    <= 1'b0;
            found_reg   <= 1'b0;
            dropped_reg <= 1'b0;
            op_reg      <= OP_APPEND;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            skip_reg    <= skip_next;
            found_reg   <= found_next;
            dropped_reg <= dropped_next;
            op_reg      <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

### hdl/olso_obuf.sv
// ----------------------------------------------------------------------------
// olso_obuf
// Two-entry output buffer that decouples the sequencer from the result
// channel's ready.
// ----------------------------------------------------------------------------
`default_nettype none

module olso_obuf (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  wire olso_pkg::olso_res_t push_data,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output olso_pkg::olso_res_t      pop_data
);

    import olso_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    olso_res_t  slot0_reg, slot0_next;
    olso_res_t  slot1_reg, slot1_next;
    logic       push;
    logic       pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = slot0_reg;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        cnt_next   = cnt_reg + {1'b0, push} - {1'b0, pop};
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                slot0_next = slot1_reg;
            end
            else if (push)
            begin
                slot0_next = push_data;
            end
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot1_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

### hdl/ordered_list_store_ops.sv
// ----------------------------------------------------------------------------
// ordered_list_store_ops
// Ordered list of signed values kept packed in one synchronous RAM.
// ----------------------------------------------------------------------------
// The block takes one request at a time. Append, clear and unused codes are
// handled in the sequencer's idle state and post their single result after it.
// Search and both removals walk the list through the RAM's one read port at
// one entry per cycle; removals write the survivors back through the write
// port behind the read pointer. Dump posts one result per entry, one per
// cycle while the result side keeps up, with last set on the final entry; an
// empty dump posts a single result with last set and zero value and count.
// A two-entry output buffer lets up to two results wait before the sequencer
// is held up. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_store_ops #(
    parameter int DEPTH = olso_pkg::DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [olso_pkg::OP_W-1:0]           op,
    input  wire logic signed [olso_pkg::VALUE_W-1:0] operand_value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [olso_pkg::VALUE_W-1:0]      entry_value,
    output logic                                     found,
    output logic                                     dropped,
    output logic [olso_pkg::COUNT_W-1:0]             entry_count,
    output logic                                     last
);

    import olso_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic               res_valid;
    logic               res_ready;
    olso_res_t          res;
    olso_res_t          head;
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [VALUE_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;

    olso_walk #(
        .DEPTH (DEPTH)
    ) u_walk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .operand_value (operand_value),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_en     (ram_rd_en),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data)
    );

    olso_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    olso_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_ready (res_ready),
        .push_data  (res),
        .pop_valid  (out_valid),
        .pop_ready  (out_ready),
        .pop_data   (head)
    );

    assign entry_value = head.entry_value;
    assign found       = head.found;
    assign dropped     = head.dropped;
    assign entry_count = head.entry_count;
    assign last        = head.last;

endmodule

`default_nettype wire

### hdl/olso_chk.sv
// ----------------------------------------------------------------------------
// olso_chk
// Port-level checks for the ordered list store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module olso_chk #(
    parameter int DEPTH = olso_pkg::DEPTH_DEF
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic [olso_pkg::OP_W-1:0]           op,
    input wire logic signed [olso_pkg::VALUE_W-1:0] operand_value,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic signed [olso_pkg::VALUE_W-1:0] entry_value,
    input wire logic                                found,
    input wire logic                                dropped,
    input wire logic [olso_pkg::COUNT_W-1:0]        entry_count,
    input wire logic                                last
);

    import olso_pkg::*;

    // A request is being worked on after it is taken, so no second one is.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while the previous one is in progress");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(entry_value)
            && $stable(last) && $stable(entry_count)))
        else $error("stalled result changed");

    a_flags_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (found || dropped)) |-> (last && !(found && dropped)))
        else $error("search or append flag on a non-final result");

    a_flag_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (found || dropped)) |-> (entry_value == '0))
        else $error("entry value set on a flagged result");

endmodule

bind ordered_list_store_ops olso_chk #(
    .DEPTH (DEPTH)
) u_olso_chk (.*);

`default_nettype wire
